// ===== src/sip_pkg.sv =====
`timescale 1ns / 1ps

package sip_pkg;

  localparam logic [63:0] InitA = 64'h736F6D6570736575;
  localparam logic [63:0] InitB = 64'h646F72616E646F6D;
  localparam logic [63:0] InitC = 64'h6C7967656E657261;
  localparam logic [63:0] InitD = 64'h7465646279746573;
  localparam logic [63:0] FinalMark = 64'h00000000000000FF;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Round counter holds two half rounds per configured round.
  localparam int unsigned RoundCntW = 5;

  typedef enum logic [1:0] {
    RegKeyLow   = 2'd0,
    RegKeyHigh  = 2'd1,
    RegCompRnds = 2'd2,
    RegFinRnds  = 2'd3
  } sip_reg_e;

  typedef enum logic [1:0] {
    KindAbsorb      = 2'd0,
    KindFinal       = 2'd1,
    KindAbsorbFinal = 2'd2
  } sip_kind_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StAbsorb = 2'd1,
    StFinal  = 2'd2
  } sip_state_e;

  typedef struct packed {
    sip_kind_e   kind;
    logic [63:0] word;
    logic [7:0]  len;
  } sip_entry_t;

  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [3:0]  comp_rounds;
    logic [3:0]  fin_rounds;
    logic        reload;
  } sip_cfg_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_lanes_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_lanes_t lanes_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_lanes_t l;
    l.a = k0 ^ InitA;
    l.b = k1 ^ InitB;
    l.c = k0 ^ InitC;
    l.d = k1 ^ InitD;
    return l;
  endfunction

  // First half of a round: the a/b and c/d adds.
  function automatic sip_lanes_t half_one(input sip_lanes_t l);
    sip_lanes_t r;
    logic [63:0] an;
    logic [63:0] cn;
    an  = l.a + l.b;
    cn  = l.c + l.d;
    r.b = rotl(l.b, 13) ^ an;
    r.d = rotl(l.d, 16) ^ cn;
    r.a = rotl(an, 32);
    r.c = cn;
    return r;
  endfunction

  // Second half of a round: the c/b and a/d adds.
  function automatic sip_lanes_t half_two(input sip_lanes_t l);
    sip_lanes_t r;
    logic [63:0] an;
    logic [63:0] cn;
    cn  = l.c + l.b;
    an  = l.a + l.d;
    r.b = rotl(l.b, 17) ^ cn;
    r.d = rotl(l.d, 21) ^ an;
    r.c = rotl(cn, 32);
    r.a = an;
    return r;
  endfunction

endpackage

// ===== src/siphash_streaming_keyed_hash.sv =====
`timescale 1ns / 1ps

// Keyed SipHash over a byte stream, one message byte per input word. The front
// end packs bytes little-endian into 64-bit words and hands each full word, and
// the closing length word, to a two-entry queue; the back end runs the rounds
// at one half round per cycle on a single shared round unit. A byte is taken
// every cycle while the queue has room. With the reset round counts the back end
// keeps pace, so the stream runs at one byte per cycle until the queue fills. The
// word marked last then gets the finalization rounds before the hash appears; if
// the last byte closes a full word, a length-only word is absorbed in between.
// The hash sits in an output register; a later hash holds the back end until it
// is taken. Program keys and round counts over the APB port only when the block
// is idle; a key write clears the partial word in the front end and reloads the
// lanes only if the back end is idle. With HASH_BITS below 64 the hash is folded
// to 32 bits, upper bits zero.
module siphash_streaming_keyed_hash #(
  parameter int unsigned HASH_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] key_low_q, key_low_d;
  logic [63:0] key_high_q, key_high_d;
  logic [3:0]  comp_q, comp_d;
  logic [3:0]  fin_q, fin_d;
  logic        cfg_wr;
  sip_pkg::sip_reg_e reg_idx;
  sip_pkg::sip_cfg_t cfg;

  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  sip_pkg::sip_entry_t front_entry;
  sip_pkg::sip_entry_t back_entry;
  logic [63:0]         hash_raw;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // Registers sit on 8-byte boundaries; offset bits are ignored.
  assign reg_idx = sip_pkg::sip_reg_e'(paddr[4:3]);

  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    comp_d     = comp_q;
    fin_d      = fin_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        sip_pkg::RegKeyLow:   key_low_d  = pwdata;
        sip_pkg::RegKeyHigh:  key_high_d = pwdata;
        sip_pkg::RegCompRnds: comp_d     = pwdata[3:0];
        sip_pkg::RegFinRnds:  fin_d      = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sip_pkg::RegKeyLow:   prdata = key_low_q;
      sip_pkg::RegKeyHigh:  prdata = key_high_q;
      sip_pkg::RegCompRnds: prdata = {60'd0, comp_q};
      sip_pkg::RegFinRnds:  prdata = {60'd0, fin_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      comp_q     <= 4'd2;
      fin_q      <= 4'd4;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
      comp_q     <= comp_d;
      fin_q      <= fin_d;
    end
  end

  // Back end reloads from the key as written this cycle.
  always_comb begin
    cfg.key_low     = key_low_d;
    cfg.key_high    = key_high_d;
    cfg.comp_rounds = comp_q;
    cfg.fin_rounds  = fin_q;
    cfg.reload      = cfg_wr &&
                      ((reg_idx == sip_pkg::RegKeyLow) || (reg_idx == sip_pkg::RegKeyHigh));
  end

  sip_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .clear_i      (cfg.reload),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (front_entry)
  );

  sip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (back_entry)
  );

  sip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .entry_i     (back_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_o      (hash_raw)
  );

  // Fold to 32 bits when the build asks for a short hash.
  assign hash_value_o = (HASH_BITS < 64) ? {32'd0, hash_raw[63:32] ^ hash_raw[31:0]}
                                         : hash_raw;

endmodule

// ===== src/sip_front.sv =====
`timescale 1ns / 1ps

module sip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                byte_valid_i,
  input  logic                last_i,
  input  logic                clear_i,
  input  logic                full_i,
  output logic                push_o,
  output sip_pkg::sip_entry_t entry_o
);

  logic [55:0] partial_q, partial_d;
  logic [2:0]  bytes_q, bytes_d;
  logic [7:0]  len_q, len_d;
  logic [55:0] partial_add;
  logic [63:0] full_word;
  logic [7:0]  len_inc;
  logic        accept;
  logic        word_done;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign word_done  = byte_valid_i && (bytes_q == 3'd7);
  assign len_inc    = len_q + {7'd0, byte_valid_i};
  assign full_word  = {data_byte_i, partial_q};

  // Drop the byte into its lane of the partial word.
  always_comb begin
    partial_add = partial_q;
    for (int i = 0; i < 7; i++) begin
      if (byte_valid_i && (bytes_q == 3'(i))) begin
        partial_add[8*i +: 8] = data_byte_i;
      end
    end
  end

  always_comb begin
    push_o        = accept && (word_done || last_i);
    entry_o.len   = len_inc;
    entry_o.word  = full_word;
    entry_o.kind  = sip_pkg::KindAbsorb;
    priority if (word_done && last_i) begin
      entry_o.kind = sip_pkg::KindAbsorbFinal;
    end else if (last_i) begin
      entry_o.kind = sip_pkg::KindFinal;
      entry_o.word = {len_inc, partial_add};
    end else begin
      entry_o.kind = sip_pkg::KindAbsorb;
    end
  end

  always_comb begin
    partial_d = partial_q;
    bytes_d   = bytes_q;
    len_d     = len_q;
    priority if (clear_i || (accept && last_i)) begin
      partial_d = '0;
      bytes_d   = '0;
      len_d     = '0;
    end else if (accept && word_done) begin
      partial_d = '0;
      bytes_d   = '0;
      len_d     = len_inc;
    end else if (accept && byte_valid_i) begin
      partial_d = partial_add;
      bytes_d   = bytes_q + 3'd1;
      len_d     = len_inc;
    end else begin
      len_d = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      bytes_q   <= '0;
      len_q     <= '0;
    end else begin
      partial_q <= partial_d;
      bytes_q   <= bytes_d;
      len_q     <= len_d;
    end
  end

endmodule

// ===== src/sip_queue.sv =====
`timescale 1ns / 1ps

module sip_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sip_pkg::sip_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output sip_pkg::sip_entry_t entry_o
);

  localparam int unsigned Depth = sip_pkg::QueueDepth;
  localparam int unsigned PtrW  = sip_pkg::QueuePtrW;
  localparam int unsigned CntW  = sip_pkg::QueueCntW;

  sip_pkg::sip_entry_t slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = do_push ? ptr_next(wr_q) : wr_q;
    rd_d  = do_pop ? ptr_next(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== src/sip_back.sv =====
`timescale 1ns / 1ps

module sip_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sip_pkg::sip_cfg_t   cfg_i,
  input  logic                empty_i,
  input  sip_pkg::sip_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         hash_o
);

  localparam int unsigned CntW = sip_pkg::RoundCntW;

  sip_pkg::sip_state_e state_q, state_d;
  sip_pkg::sip_lanes_t lanes_q, lanes_d;
  sip_pkg::sip_lanes_t lanes_step;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [63:0]         word_q, word_d;
  logic [7:0]          len_q, len_d;
  logic                fin_q, fin_d;
  logic                extra_q, extra_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         hash_q, hash_d;
  logic [63:0]         len_word;

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;
  assign len_word    = {len_q, 56'd0};

  // Even count: first half of the round, odd: second half.
  assign lanes_step = cnt_q[0] ? sip_pkg::half_two(lanes_q) : sip_pkg::half_one(lanes_q);

  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    len_d       = len_q;
    fin_d       = fin_q;
    extra_d     = extra_q;
    out_valid_d = out_valid_q && out_stall_i;
    hash_d      = hash_q;
    pop_o       = 1'b0;
    unique case (state_q)
      sip_pkg::StIdle: begin
        if (cfg_i.reload) begin
          lanes_d = sip_pkg::lanes_init(cfg_i.key_low, cfg_i.key_high);
        end else if (!empty_i) begin
          pop_o     = 1'b1;
          word_d    = entry_i.word;
          len_d     = entry_i.len;
          fin_d     = (entry_i.kind != sip_pkg::KindAbsorb);
          extra_d   = (entry_i.kind == sip_pkg::KindAbsorbFinal);
          lanes_d.d = lanes_q.d ^ entry_i.word;
          cnt_d     = {cfg_i.comp_rounds, 1'b0};
          state_d   = sip_pkg::StAbsorb;
        end
      end
      sip_pkg::StAbsorb: begin
        if (cnt_q != '0) begin
          lanes_d = lanes_step;
          cnt_d   = cnt_q - CntW'(1);
        end else begin
          lanes_d.a = lanes_q.a ^ word_q;
          priority if (extra_q) begin
            // Full word closed the message: chain the length-only word.
            word_d    = len_word;
            lanes_d.d = lanes_q.d ^ len_word;
            extra_d   = 1'b0;
            cnt_d     = {cfg_i.comp_rounds, 1'b0};
          end else if (fin_q) begin
            lanes_d.c = lanes_q.c ^ sip_pkg::FinalMark;
            cnt_d     = {cfg_i.fin_rounds, 1'b0};
            state_d   = sip_pkg::StFinal;
          end else begin
            state_d = sip_pkg::StIdle;
          end
        end
      end
      sip_pkg::StFinal: begin
        if (cnt_q != '0) begin
          lanes_d = lanes_step;
          cnt_d   = cnt_q - CntW'(1);
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          hash_d      = lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
          lanes_d     = sip_pkg::lanes_init(cfg_i.key_low, cfg_i.key_high);
          state_d     = sip_pkg::StIdle;
        end
      end
      default: begin
        state_d = sip_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sip_pkg::StIdle;
      lanes_q     <= sip_pkg::lanes_init('0, '0);
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      extra_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lanes_q     <= lanes_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      extra_q     <= extra_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    len_q  <= len_d;
    hash_q <= hash_d;
  end

`ifndef ASSERT_OFF
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sip_pkg::StIdle && cnt_q != '0) |=>
      (cnt_q == CntW'($past(cnt_q) - CntW'(1))))
    else $error("round counter skipped a half round");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == sip_pkg::StIdle && !empty_i))
    else $error("queue popped outside idle");
`endif

endmodule
